/* rtl/scrod_pkg.sv */
// Shared types and constants of the SCReLU output dot-product core.
// No dependencies; every other file of the core depends on this package.
package scrod_pkg;

    // Default values of the top-level parameters
    localparam int QA_LIMIT_DEF    = 255;
    localparam int QB_SCALE_DEF    = 64;
    localparam int OUT_SCALE_DEF   = 400;
    localparam int NUM_BUCKETS_DEF = 8;

    // Field and port widths fixed by the interface
    localparam int ACT_W    = 16;
    localparam int WGT_W    = 8;
    localparam int BKT_W    = 3;
    localparam int SUM_W    = 32;
    localparam int EVAL_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // One finished dot product waiting for the output stage
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [BKT_W-1:0] bucket;
    } job_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL,
        ST_START2,
        ST_DIV2,
        ST_PUT
    } back_state_t;

endpackage

/* rtl/scrod_front.sv */
// Front part: clamps, squares and weights each activation, accumulates the sum.
// Pushes a job into the queue on the item marked last. Depends on scrod_pkg.
module scrod_front #(
    parameter int QA_LIMIT = scrod_pkg::QA_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [scrod_pkg::ACT_W-1:0] activation,
    input  logic signed [scrod_pkg::WGT_W-1:0] weight,
    input  logic [scrod_pkg::BKT_W-1:0]        bucket,
    input  logic                               last,
    output logic                               q_push,
    output scrod_pkg::job_t                    q_data,
    input  logic                               q_full
);
    import scrod_pkg::*;

    localparam int QA_W = $clog2(QA_LIMIT + 1);
    localparam int SQ_W = 2 * QA_W;

    logic               s1_valid_reg, s1_valid_next;
    logic [SQ_W-1:0]    s1_sq_reg;
    logic [WGT_W-1:0]   s1_wgt_reg;
    logic [BKT_W-1:0]   s1_bkt_reg;
    logic               s1_last_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic               accept;
    logic               s1_ready;
    logic               s1_fire;
    logic [QA_W-1:0]    clamped;
    logic [SQ_W-1:0]    square;
    logic [SUM_W-1:0]   product;
    logic [SUM_W-1:0]   sum_add;

    // Stall only while a last item waits for room in the queue
    assign s1_ready = !(s1_valid_reg && s1_last_reg && q_full);
    assign full     = !s1_ready;
    assign accept   = push && s1_ready;
    assign s1_fire  = s1_valid_reg && s1_ready;

    // Clamp to 0..QA_LIMIT and square
    always_comb
    begin
        if (activation[ACT_W-1])
            clamped = '0;
        else if ({1'b0, activation[ACT_W-2:0]} > ACT_W'(QA_LIMIT))
            clamped = QA_W'(QA_LIMIT);
        else
            clamped = activation[QA_W-1:0];
    end

    assign square = SQ_W'(clamped) * SQ_W'(clamped);

    // Weight the square and add into the wrapping sum
    assign product = SUM_W'(s1_sq_reg) * {{(SUM_W-WGT_W){s1_wgt_reg[WGT_W-1]}}, s1_wgt_reg};
    assign sum_add = sum_reg + product;

    assign q_push        = s1_fire && s1_last_reg;
    assign q_data.sum    = sum_add;
    assign q_data.bucket = s1_bkt_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_ready)
            s1_valid_next = 1'b0;

        sum_next = sum_reg;
        if (s1_fire)
            sum_next = s1_last_reg ? '0 : sum_add;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
        end
    end

    // Advance the stage-one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg   <= square;
            s1_wgt_reg  <= weight;
            s1_bkt_reg  <= bucket;
            s1_last_reg <= last;
        end
    end

endmodule

/* rtl/scrod_fifo.sv */
// Short queue of finished dot products between the front and back parts.
// Depends on scrod_pkg for the job type.
module scrod_fifo #(
    parameter int DEPTH = scrod_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  scrod_pkg::job_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output scrod_pkg::job_t rd_data,
    output logic            empty
);
    import scrod_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/scrod_div.sv */
// Unsigned division by a constant through a reciprocal multiply, taking the
// reciprocal 16 bits per cycle, most significant first. Depends on scrod_pkg for defaults.
module scrod_div #(
    parameter int NUM_W   = scrod_pkg::SUM_W,
    parameter int DIVISOR = scrod_pkg::QA_LIMIT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int SH     = $clog2(DIVISOR);
    localparam int CH_W   = 16;
    localparam int STEPS  = (NUM_W + CH_W) / CH_W;
    localparam int MAG_W  = STEPS * CH_W;
    localparam int EXT_W  = NUM_W + SH + 1;
    localparam int PROD_W = NUM_W + MAG_W + SH;
    localparam int PART_W = NUM_W + CH_W;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    // Reciprocal rounded up: ceil(2^(NUM_W+SH) / DIVISOR), exact for every NUM_W-bit numerator
    localparam logic [EXT_W-1:0] POW_EXT   = EXT_W'(1) << (NUM_W + SH);
    localparam logic [EXT_W-1:0] RECIP_EXT =
        (POW_EXT + EXT_W'(DIVISOR - 1)) / EXT_W'(DIVISOR);
    localparam logic [MAG_W-1:0] RECIP     = MAG_W'(RECIP_EXT);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [MAG_W-1:0]   rcp_reg, rcp_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PART_W-1:0]  partial;

    // Numerator times the current 16-bit slice of the reciprocal
    assign partial = PART_W'(num_reg) * PART_W'(rcp_reg[MAG_W-1 -: CH_W]);

    // Accumulate the product slice by slice, shifting the running total up
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rcp_next  = rcp_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
            num_next  = numer;
            rcp_next  = RECIP;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << CH_W) + PROD_W'(partial);
            rcp_next = rcp_reg << CH_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rcp_reg <= rcp_next;
        acc_reg <= acc_next;
    end

    // Drop the fraction bits of the product
    assign quotient = acc_reg[NUM_W+SH +: NUM_W];
    assign done     = done_reg;

endmodule

/* rtl/scrod_back.sv */
// Back part: bias registers, scaling sequencer around the two constant dividers,
// saturation and the result register. Depends on scrod_pkg and scrod_div.
module scrod_back #(
    parameter int QA_LIMIT    = scrod_pkg::QA_LIMIT_DEF,
    parameter int QB_SCALE    = scrod_pkg::QB_SCALE_DEF,
    parameter int OUT_SCALE   = scrod_pkg::OUT_SCALE_DEF,
    parameter int NUM_BUCKETS = scrod_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scrod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scrod_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  scrod_pkg::job_t                     q_data,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [scrod_pkg::EVAL_W-1:0] eval
);
    import scrod_pkg::*;

    localparam int OS_W  = $clog2(OUT_SCALE + 1);
    localparam int NUM_W = SUM_W + OS_W;
    localparam int BK_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int TOT_W = SUM_W + 2;
    localparam int QAQB  = QA_LIMIT * QB_SCALE;
    localparam logic [NUM_W-1:0] POS_MAX  = NUM_W'(32'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_MAX  = NUM_W'(32'h8000_0000);

    back_state_t        state_reg, state_next;
    logic [SUM_W-1:0]   bias_reg [NUM_BUCKETS];
    logic               neg_reg, neg_next;
    logic [BK_W-1:0]    bsel_reg, bsel_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [NUM_W-1:0]   prod_reg, prod_next;
    logic [EVAL_W-1:0]  ev_reg, ev_next;
    logic               out_valid_reg, out_valid_next;
    logic [EVAL_W-1:0]  eval_reg, eval_next;

    logic               div1_start;
    logic [SUM_W-1:0]   div1_quo;
    logic               div1_done;
    logic               div2_start;
    logic [NUM_W-1:0]   div2_quo;
    logic               div2_done;

    logic [SUM_W-1:0]   head_mag;
    logic [BK_W-1:0]    head_bsel;
    logic [TOT_W-1:0]   q_signed;
    logic [SUM_W-1:0]   bias_sel;
    logic [TOT_W-1:0]   total_calc;
    logic [SUM_W:0]     total_mag;
    logic [EVAL_W-1:0]  ev_sat;

    // Magnitude of the sum divided by QA
    scrod_div #(
        .NUM_W   (SUM_W),
        .DIVISOR (QA_LIMIT)
    ) u_div_qa (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div1_start),
        .numer    (head_mag),
        .quotient (div1_quo),
        .done     (div1_done)
    );

    // Magnitude of the scaled total divided by QA*QB
    scrod_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (QAQB)
    ) u_div_qaqb (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div2_start),
        .numer    (prod_reg),
        .quotient (div2_quo),
        .done     (div2_done)
    );

    // Magnitude of the queued sum and its saturated bucket
    assign head_mag  = q_data.sum[SUM_W-1] ? (SUM_W'(0) - q_data.sum) : q_data.sum;
    assign head_bsel = ({1'b0, q_data.bucket} >= (BKT_W+1)'(NUM_BUCKETS))
                       ? BK_W'(NUM_BUCKETS - 1) : BK_W'(q_data.bucket);

    // Signed first quotient plus the selected bias
    assign q_signed   = neg_reg ? (TOT_W'(0) - TOT_W'(div1_quo))
                                : TOT_W'(div1_quo);
    assign bias_sel   = bias_reg[bsel_reg];
    assign total_calc = q_signed + {{(TOT_W-SUM_W){bias_sel[SUM_W-1]}}, bias_sel};
    assign total_mag  = total_reg[TOT_W-1] ? (SUM_W+1)'(TOT_W'(0) - total_reg)
                                           : total_reg[SUM_W:0];

    // Saturate the final quotient to signed 32 bits
    always_comb
    begin
        if (neg_reg)
            ev_sat = (div2_quo > NEG_MAX) ? EVAL_W'(32'h8000_0000)
                                          : (EVAL_W'(0) - div2_quo[EVAL_W-1:0]);
        else
            ev_sat = (div2_quo > POS_MAX) ? EVAL_W'(32'h7FFF_FFFF) : div2_quo[EVAL_W-1:0];
    end

    // Sequence one job: divide, add bias, scale, divide, saturate, hand over
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        bsel_next      = bsel_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg && !pop;
        eval_next      = eval_reg;
        div1_start     = 1'b0;
        div2_start     = 1'b0;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    neg_next   = q_data.sum[SUM_W-1];
                    bsel_next  = head_bsel;
                    div1_start = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div1_done)
                begin
                    total_next = total_calc;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                neg_next   = total_reg[TOT_W-1];
                prod_next  = NUM_W'(total_mag) * NUM_W'(OUT_SCALE);
                state_next = ST_START2;
            end
            ST_START2:
            begin
                div2_start = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div2_done)
                begin
                    ev_next    = ev_sat;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    eval_next      = ev_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and bias registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
                bias_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(NUM_BUCKETS)))
                bias_reg[cfg_index[BK_W-1:0]] <= cfg_data;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        bsel_reg  <= bsel_next;
        total_reg <= total_next;
        prod_reg  <= prod_next;
        ev_reg    <= ev_next;
        eval_reg  <= eval_next;
    end

    assign empty = !out_valid_reg;
    assign eval  = eval_reg;

endmodule

/* rtl/screlu_output_dot_product_core.sv */
// Top level of the SCReLU output dot-product core: front MAC, job queue, back scaler.
// Depends on scrod_pkg, scrod_front, scrod_fifo, scrod_back (and scrod_div below it).
//
//  channel  | signals                               | transfer when
//  ---------+---------------------------------------+--------------------
//  input    | activation, weight, bucket, last      | push && !full
//  result   | eval                                  | pop && !empty
//  config   | cfg_we, cfg_index, cfg_data           | cfg_we
//
// Items enter at one per cycle through a two-stage clamp/square/weight-accumulate pipe.
// Each item marked last queues its sum; the back part takes one job at a time, dividing by
// QA and then by QA*QB with reciprocal multiplies in 16-bit steps, and hands the result
// over once the previous one has been popped. Input stalls only when the two-entry queue
// is full and a last item waits.
// Reset clears the sum, the queue and the biases, and marks the result register empty.
module screlu_output_dot_product_core #(
    parameter int QA_LIMIT    = scrod_pkg::QA_LIMIT_DEF,
    parameter int QB_SCALE    = scrod_pkg::QB_SCALE_DEF,
    parameter int OUT_SCALE   = scrod_pkg::OUT_SCALE_DEF,
    parameter int NUM_BUCKETS = scrod_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [scrod_pkg::ACT_W-1:0]  activation,
    input  logic signed [scrod_pkg::WGT_W-1:0]  weight,
    input  logic [scrod_pkg::BKT_W-1:0]         bucket,
    input  logic                                last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [scrod_pkg::EVAL_W-1:0] eval,
    input  logic                                cfg_we,
    input  logic [scrod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scrod_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import scrod_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t q_in;
    job_t q_out;

    scrod_front #(
        .QA_LIMIT (QA_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .activation (activation),
        .weight     (weight),
        .bucket     (bucket),
        .last       (last),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    scrod_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    scrod_back #(
        .QA_LIMIT    (QA_LIMIT),
        .QB_SCALE    (QB_SCALE),
        .OUT_SCALE   (OUT_SCALE),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_data    (q_out),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .eval      (eval)
    );

    // Input backpressure only comes from a full job queue
    a_full_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("input stalled while the job queue had room");

    // Never push a job into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    // Never take a job from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

endmodule

/* bench/screlu_eval_checker.sv */
// Checker for the SCReLU output dot-product core: watches the input, result and config
// channels, predicts each evaluation, and compares results in order. Needs scrod_pkg.
module screlu_eval_checker #(
    parameter int QA_LIMIT    = scrod_pkg::QA_LIMIT_DEF,
    parameter int QB_SCALE    = scrod_pkg::QB_SCALE_DEF,
    parameter int OUT_SCALE   = scrod_pkg::OUT_SCALE_DEF,
    parameter int NUM_BUCKETS = scrod_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic signed [scrod_pkg::ACT_W-1:0]  activation,
    input  logic signed [scrod_pkg::WGT_W-1:0]  weight,
    input  logic [scrod_pkg::BKT_W-1:0]         bucket,
    input  logic                                last,
    input  logic                                empty,
    input  logic                                pop,
    input  logic signed [scrod_pkg::EVAL_W-1:0] eval,
    input  logic                                cfg_we,
    input  logic [scrod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scrod_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                                end_check,
    output int                                  errors,
    output int                                  outstanding
);
    import scrod_pkg::*;

    localparam int BIAS_REGS = 8;

    logic [SUM_W-1:0]      dot_sum;
    logic [CFG_DAT_W-1:0]  bias_copy [BIAS_REGS];
    logic [EVAL_W-1:0]     eval_due [$];
    int                    fail_cnt = 0;
    bit                    end_done = 1'b0;

    // Clamp to 0..QA, square, weight; everything wraps at 32 bits
    function automatic logic [SUM_W-1:0] weighted_square(logic signed [ACT_W-1:0] a,
                                                         logic signed [WGT_W-1:0] w);
        logic [SUM_W-1:0] lvl;
        if (a < 0)
            lvl = '0;
        else if (a > QA_LIMIT)
            lvl = SUM_W'(QA_LIMIT);
        else
            lvl = SUM_W'(a);
        return lvl * lvl * {{(SUM_W-WGT_W){w[WGT_W-1]}}, w};
    endfunction

    // Scale a finished sum with the bias of its bucket and saturate to 32 bits
    function automatic logic [EVAL_W-1:0] scaled_eval(logic [SUM_W-1:0] sum,
                                                      logic [BKT_W-1:0] bkt);
        int     idx;
        longint q;
        longint total;
        longint ev;
        idx = (bkt >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : int'(bkt);
        q = longint'($signed(sum)) / QA_LIMIT;
        total = q + longint'($signed(bias_copy[idx]));
        ev = (total * OUT_SCALE) / (longint'(QA_LIMIT) * QB_SCALE);
        if (ev > 64'sd2147483647)
            ev = 64'sd2147483647;
        if (ev < -64'sd2147483648)
            ev = -64'sd2147483648;
        return ev[EVAL_W-1:0];
    endfunction

    task automatic report_fail(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [EVAL_W-1:0] want;
        if (!rst_n)
        begin
            // Clear the sum, the biases and anything still expected
            dot_sum = '0;
            foreach (bias_copy[i])
                bias_copy[i] = '0;
            eval_due.delete();
            outstanding <= 0;
            errors <= fail_cnt;
        end
        else
        begin
            // Track bias writes
            if (cfg_we && cfg_index < BIAS_REGS)
                bias_copy[cfg_index] = cfg_data;

            // Accumulate each input transfer; a last item closes the dot product
            if (push && !full)
            begin
                dot_sum = dot_sum + weighted_square(activation, weight);
                if (last)
                begin
                    eval_due.push_back(scaled_eval(dot_sum, bucket));
                    dot_sum = '0;
                end
            end

            // Compare each result transfer with the oldest expectation
            if (pop && !empty)
            begin
                if (eval_due.size() == 0)
                    report_fail($sformatf("unexpected result eval=%0d", eval));
                else
                begin
                    want = eval_due.pop_front();
                    if (eval !== want)
                        report_fail($sformatf("eval got %0d want %0d", eval, $signed(want)));
                end
            end

            // Flag expectations that never arrived
            if (end_check && !end_done)
            begin
                end_done = 1'b1;
                if (eval_due.size() != 0)
                    report_fail($sformatf("%0d expected results never arrived",
                                          eval_due.size()));
            end

            outstanding <= eval_due.size();
            errors <= fail_cnt;
        end
    end

endmodule

/* bench/tb_screlu_output_dot_product_core.sv */
// Testbench top for the SCReLU output dot-product core: clock, reset, bias loads and
// item stimulus with random idling. Needs scrod_pkg, the core and screlu_eval_checker.
module tb_screlu_output_dot_product_core;
    import scrod_pkg::*;

    localparam int QA          = QA_LIMIT_DEF;
    localparam int DRAIN_LIMIT = 40000;
    localparam int SETTLE      = 150;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic signed [ACT_W-1:0] activation;
    logic signed [WGT_W-1:0] weight;
    logic [BKT_W-1:0]        bucket;
    logic                    last;
    logic                    empty;
    logic                    pop;
    logic signed [EVAL_W-1:0] eval;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    end_check;
    int                      fail_total;
    int                      results_due;

    bit                      idle_on = 1'b0;
    bit                      allow_idle = 1'b0;
    logic [CFG_DAT_W-1:0]    bias_plan [8];

    screlu_output_dot_product_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .activation (activation),
        .weight     (weight),
        .bucket     (bucket),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .eval       (eval),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    screlu_eval_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .activation  (activation),
        .weight      (weight),
        .bucket      (bucket),
        .last        (last),
        .empty       (empty),
        .pop         (pop),
        .eval        (eval),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_check   (end_check),
        .errors      (fail_total),
        .outstanding (results_due)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #10000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: take results, stalling in random bursts while idling is on
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(logic signed [ACT_W-1:0] a, logic signed [WGT_W-1:0] w,
                             logic [BKT_W-1:0] b, logic l);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        activation <= a;
        weight <= w;
        bucket <= b;
        last <= l;
        do
            @(posedge clk);
        while (full);
    endtask

    // Hold the input until every expected result has come, then let the back part settle
    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all eight biases back to back; only call while idle
    task automatic load_biases();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= bias_plan[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Choose a bias setting: all max, all min, alternating extremes, or random
    task automatic plan_biases(int mode);
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: bias_plan[i] = 32'h7FFF_FFFF;
                1: bias_plan[i] = 32'h8000_0000;
                2: bias_plan[i] = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                3: bias_plan[i] = 32'($urandom_range(0, 200000)) - 32'd100000;
                default: bias_plan[i] = $urandom();
            endcase
        end
    endtask

    function automatic logic signed [ACT_W-1:0] pick_activation();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ACT_W'($urandom_range(0, QA));
            5: return ACT_W'($urandom_range(32768, 65535));
            6: return ACT_W'($urandom_range(QA + 1, 32767));
            7:
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'hFFFF;
                    2: return 16'h0000;
                    3: return ACT_W'(QA);
                    4: return ACT_W'(QA + 1);
                    default: return 16'h7FFF;
                endcase
            default: return ACT_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [WGT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7F;
            default: return WGT_W'($urandom());
        endcase
    endfunction

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        else if (roll < 95)
            return $urandom_range(9, 32);
        return $urandom_range(33, 100);
    endfunction

    // One dot product of random content; bucket is random on every item
    task automatic send_random_dot(int len);
        for (int i = 0; i < len; i++)
            send_item(pick_activation(), pick_weight(), BKT_W'($urandom()), i == len - 1);
    endtask

    // A long dot product of saturated activations, to wrap the running sum
    task automatic send_heavy_dot(logic signed [WGT_W-1:0] w, int len);
        for (int i = 0; i < len; i++)
            send_item(ACT_W'($urandom_range(QA, 32767)), w, BKT_W'($urandom()), i == len - 1);
    endtask

    task automatic random_phase(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = pick_len();
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            send_random_dot(len);
            sent += len;
        end
    endtask

    // Main stimulus
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        activation = '0;
        weight = '0;
        bucket = '0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        end_check = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, with the reset biases: field extremes, clamping, multi-item sums
        send_item(16'sh7FFF, 8'sh7F, 3'd0, 1'b1);
        send_item(-16'sh8000, -8'sh80, 3'd1, 1'b1);
        send_item(ACT_W'(QA), -8'sh80, 3'd7, 1'b1);
        send_item(ACT_W'(QA + 1), 8'sh7F, 3'd2, 1'b0);
        send_item(16'sh0001, 8'sh01, 3'd5, 1'b0);
        send_item(-16'sh0001, -8'sh01, 3'd2, 1'b1);
        send_item(16'sh0000, 8'sh00, 3'd3, 1'b1);
        send_item(ACT_W'(QA - 1), 8'sh7F, 3'd4, 1'b0);
        send_item(ACT_W'(QA), -8'sh01, 3'd4, 1'b1);
        drain();

        // Directed, with alternating extreme biases
        plan_biases(2);
        load_biases();
        send_item(16'sh7FFF, 8'sh7F, 3'd0, 1'b1);
        send_item(16'sh7FFF, 8'sh7F, 3'd1, 1'b1);
        send_item(16'sh7FFF, -8'sh80, 3'd2, 1'b1);
        send_item(16'sh7FFF, -8'sh80, 3'd3, 1'b1);
        send_item(16'sh0064, 8'sh05, 3'd6, 1'b0);
        send_item(-16'sh0005, 8'sh05, 3'd6, 1'b1);
        send_item(16'sh00AA, -8'sh33, 3'd5, 1'b1);
        send_item(16'sh0055, 8'sh55, 3'd7, 1'b1);
        drain();

        // Random phases, each under a new bias setting; the last one runs without idling
        for (int p = 0; p < 5; p++)
        begin
            plan_biases(p);
            load_biases();
            allow_idle = (p != 4);
            idle_on = allow_idle;
            if (p == 1)
                send_heavy_dot(8'sh7F, 270);
            if (p == 2)
                send_heavy_dot(-8'sh80, 270);
            random_phase(90);
            drain();
        end

        // Let the last results come, then check for leftovers and give the verdict
        idle_on = 1'b0;
        end_check <= 1'b1;
        repeat (3) @(posedge clk);
        if (fail_total == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
